/* sv/its_pkg.sv */
// its_pkg: shared types, token codes and keyword tables for the IDL token scanner.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package its_pkg;

  // Field widths fixed by the token format
  localparam int KIND_W   = 5;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 5;
  localparam int WLEN_W   = 6;
  // Internal word length, wide enough for the longest supported word (64)
  localparam int LEN_W    = 7;

  localparam int NUM_KW   = 12;
  localparam int KW_CHARS = 10;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd13;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd14;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd15;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd16;
  localparam logic [KIND_W-1:0] KIND_LANGLE = 5'd17;
  localparam logic [KIND_W-1:0] KIND_RANGLE = 5'd18;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd19;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd20;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  // Keyword text, left aligned and space padded; first character in the top byte
  typedef logic [KW_CHARS*CHAR_W-1:0] kw_text_t;

  localparam kw_text_t KW_TEXT [NUM_KW] = '{
    "class     ", "namespace ", "Int8      ", "Int16     ",
    "Int32     ", "Int64     ", "map       ", "vector    ",
    "bool      ", "string    ", "float     ", "out       "
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd9, 4'd4, 4'd5, 4'd5, 4'd5, 4'd3, 4'd6, 4'd4, 4'd6, 4'd5, 4'd3
  };

  // Command passed from the front end to the emitter
  typedef struct packed {
    logic              has_word;
    logic              has_sep;
    logic [KIND_W-1:0] sep_kind;
    logic [KIND_W-1:0] kw_kind;   // KIND_IDENT when the word is an identifier
    logic [LEN_W-1:0]  len;
    logic              trunc;
    logic              bank;
  } cmd_t;

  // One result token
  typedef struct packed {
    logic [KIND_W-1:0]  token_kind;
    logic [CHAR_W-1:0]  word_char;
    logic [INDEX_W-1:0] char_index;
    logic [WLEN_W-1:0]  word_length;
    logic               word_truncated;
    logic               last;
  } result_t;

  // Character of keyword k at position pos, zero past the table
  function automatic logic [CHAR_W-1:0] kw_char(input logic [3:0] k, input logic [3:0] pos);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (k < 4'(NUM_KW) && pos < 4'(KW_CHARS)) begin
      ch = KW_TEXT[k][CHAR_W*(KW_CHARS-1-int'(pos)) +: CHAR_W];
    end
    return ch;
  endfunction

  function automatic logic is_white(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // Separator kind, KIND_IDENT when the byte is not a separator
  function automatic logic [KIND_W-1:0] sep_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_COMMA:  k = KIND_COMMA;
      CH_SEMI:   k = KIND_SEMI;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LANGLE: k = KIND_LANGLE;
      CH_RANGLE: k = KIND_RANGLE;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      default:   k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

/* sv/its_if.sv */
// its_in_if / its_out_if: valid/ready channels for text bytes and result tokens.
// No dependencies.
`timescale 1ns / 1ps

interface its_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface its_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic [7:0] word_char;
  logic [4:0] char_index;
  logic [5:0] word_length;
  logic       word_truncated;
  logic       last;

  modport source (output valid, output token_kind, output word_char, output char_index,
                  output word_length, output word_truncated, output last, input ready);
  modport sink   (input valid, input token_kind, input word_char, input char_index,
                  input word_length, input word_truncated, input last, output ready);
endinterface

/* sv/its_front.sv */
// its_front: byte classifier, incremental keyword matcher and two-bank word buffer.
// Depends on its_pkg. Pushes one command per request that produces tokens.
`timescale 1ns / 1ps

module its_front #(
  parameter int MAX_WORD = 32,
  parameter int ADDR_W   = $clog2(MAX_WORD) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          text_char,
  input  logic                end_of_text,
  output logic                push,
  output its_pkg::cmd_t       cmd,
  input  logic                fifo_full,
  input  logic                word_done,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [7:0]          rd_data
);
  import its_pkg::*;

  localparam int IW    = ADDR_W - 1;
  localparam int LW    = $clog2(MAX_WORD + 1);
  localparam int DEPTH = 2 ** ADDR_W;
  localparam logic [1:0] OUTST_MAX = 2'd2;

  logic              in_word_r, in_word_nxt;
  logic [LW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [NUM_KW-1:0] cand_r, cand_nxt;
  logic              bank_r;
  logic [1:0]        outst_r, outst_nxt;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data_r;

  logic              accept;
  logic              white;
  logic [KIND_W-1:0] sk;
  logic              is_sep;
  logic              end_now, start, append, word_active, word_end;
  logic [LW-1:0]     base_cnt, cnt_a;
  logic              base_ovf, ovf_a, room;
  logic [NUM_KW-1:0] base_cand, cand_app, cand_a;
  logic [KIND_W-1:0] kw;
  logic              wr_en;

  // Hold off while the queue is full, or between words while both buffer banks are still in use
  assign in_ready = !fifo_full && (in_word_r || outst_r != OUTST_MAX);
  assign accept   = in_valid && in_ready;

  // Classification and word bookkeeping
  always_comb begin
    white       = is_white(text_char);
    sk          = sep_kind(text_char);
    is_sep      = (sk != KIND_IDENT);
    end_now     = in_word_r && (white || is_sep);
    start       = !in_word_r && !white && !is_sep;
    append      = (in_word_r && !white && !is_sep) || start;
    word_active = (in_word_r && !end_now) || start;
    word_end    = end_now || (end_of_text && word_active);

    base_cnt  = start ? '0 : cnt_r;
    base_ovf  = start ? 1'b0 : ovf_r;
    base_cand = start ? '1 : cand_r;
    room      = base_cnt < LW'(MAX_WORD);

    // A keyword stays a candidate while every stored byte matches its text
    for (int k = 0; k < NUM_KW; k++) begin
      cand_app[k] = base_cand[k] && (base_cnt < LW'(KW_LEN[k])) &&
                    (kw_char(4'(k), 4'(base_cnt)) == text_char);
    end

    cnt_a  = cnt_r;
    ovf_a  = ovf_r;
    cand_a = cand_r;
    if (append) begin
      if (room) begin
        cnt_a  = base_cnt + LW'(1);
        ovf_a  = base_ovf;
        cand_a = cand_app;
      end else begin
        cnt_a  = base_cnt;
        ovf_a  = 1'b1;
        cand_a = base_cand;
      end
    end
    wr_en = accept && append && room;

    // Exact-length match of a surviving candidate; truncated words never match
    kw = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand_a[k] && LW'(KW_LEN[k]) == cnt_a && !ovf_a) begin
        kw = KIND_W'(k + 1);
      end
    end

    cmd.has_word = word_end;
    cmd.has_sep  = is_sep;
    cmd.sep_kind = sk;
    cmd.kw_kind  = kw;
    cmd.len      = LEN_W'(cnt_a);
    cmd.trunc    = ovf_a;
    cmd.bank     = bank_r;
    push         = accept && (word_end || is_sep);

    if (word_end) begin
      in_word_nxt = 1'b0;
      cnt_nxt     = '0;
      ovf_nxt     = 1'b0;
      cand_nxt    = '0;
    end else begin
      in_word_nxt = word_active;
      cnt_nxt     = cnt_a;
      ovf_nxt     = ovf_a;
      cand_nxt    = cand_a;
    end

    outst_nxt = outst_r + 2'(push && word_end) - 2'(word_done);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r <= 1'b0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      cand_r    <= '0;
      bank_r    <= 1'b0;
      outst_r   <= '0;
    end else begin
      outst_r <= outst_nxt;
      if (accept) begin
        in_word_r <= in_word_nxt;
        cnt_r     <= cnt_nxt;
        ovf_r     <= ovf_nxt;
        cand_r    <= cand_nxt;
        if (word_end) begin
          bank_r <= !bank_r;
        end
      end
    end
  end

  // Word buffer: write from the classifier, registered read for the emitter
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{bank_r, base_cnt[IW-1:0]}] <= text_char;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

  // Never more words held than there are buffer banks
  a_outst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r <= OUTST_MAX)
    else $error("word buffer banks over-committed");

  // Stored length never exceeds the buffer size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LW'(MAX_WORD))
    else $error("word count beyond buffer size");

endmodule

/* sv/its_cmd_fifo.sv */
// its_cmd_fifo: two-entry command queue between the classifier and the emitter.
// Depends on its_pkg.
`timescale 1ns / 1ps

module its_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  its_pkg::cmd_t push_cmd,
  input  logic          pop,
  output its_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import its_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       store_r [DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'(DEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign head    = store_r[rd_ptr_r];
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop) && !(pop && empty))
    else $error("command queue overrun or underrun");

endmodule

/* sv/its_back.sv */
// its_back: token emitter. Expands queued commands into result tokens, reading
// identifier characters from the word buffer. Depends on its_pkg.
`timescale 1ns / 1ps

module its_back #(
  parameter int MAX_WORD = 32,
  parameter int ADDR_W   = $clog2(MAX_WORD) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fifo_empty,
  input  its_pkg::cmd_t       head,
  output logic                pop,
  output logic [ADDR_W-1:0]   rd_addr,
  input  logic [7:0]          rd_data,
  output logic                word_done,
  output logic                out_valid,
  input  logic                out_ready,
  output its_pkg::result_t    out_res
);
  import its_pkg::*;

  localparam int IW = ADDR_W - 1;
  localparam int LW = $clog2(MAX_WORD + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KW,
    ST_CHARS,
    ST_SEP
  } state_t;

  state_t        state_r;
  cmd_t          cmd_r;
  logic [IW-1:0] idx_r;
  logic          out_valid_r;
  result_t       res_r;

  logic          can_load;
  logic          last_char;
  logic [LW-1:0] len_l;

  assign can_load  = !out_valid_r || out_ready;
  assign len_l     = cmd_r.len[LW-1:0];
  assign last_char = (LW'(idx_r) + LW'(1)) == len_l;
  assign pop       = (state_r == ST_IDLE) && !fifo_empty;
  assign word_done = can_load && ((state_r == ST_KW) || (state_r == ST_CHARS && last_char));

  // Read address runs one ahead so each character has its data ready
  always_comb begin
    unique case (state_r)
      ST_IDLE:  rd_addr = {head.bank, IW'(0)};
      ST_CHARS: rd_addr = {cmd_r.bank, (can_load && !last_char) ? idx_r + IW'(1) : idx_r};
      default:  rd_addr = {cmd_r.bank, idx_r};
    endcase
  end

  // Sequencer with registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!fifo_empty) begin
            cmd_r <= head;
            idx_r <= '0;
            if (!head.has_word) begin
              state_r <= ST_SEP;
            end else if (head.kw_kind != KIND_IDENT) begin
              state_r <= ST_KW;
            end else begin
              state_r <= ST_CHARS;
            end
          end
        end
        ST_KW: begin
          if (can_load) begin
            out_valid_r          <= 1'b1;
            res_r.token_kind     <= cmd_r.kw_kind;
            res_r.word_char      <= '0;
            res_r.char_index     <= '0;
            res_r.word_length    <= WLEN_W'(cmd_r.len);
            res_r.word_truncated <= 1'b0;
            res_r.last           <= !cmd_r.has_sep;
            state_r              <= cmd_r.has_sep ? ST_SEP : ST_IDLE;
          end
        end
        ST_CHARS: begin
          if (can_load) begin
            out_valid_r          <= 1'b1;
            res_r.token_kind     <= KIND_IDENT;
            res_r.word_char      <= rd_data;
            res_r.char_index     <= INDEX_W'(idx_r);
            res_r.word_length    <= WLEN_W'(cmd_r.len);
            res_r.word_truncated <= cmd_r.trunc;
            res_r.last           <= last_char && !cmd_r.has_sep;
            if (last_char) begin
              state_r <= cmd_r.has_sep ? ST_SEP : ST_IDLE;
            end else begin
              idx_r <= idx_r + IW'(1);
            end
          end
        end
        ST_SEP: begin
          if (can_load) begin
            out_valid_r          <= 1'b1;
            res_r.token_kind     <= cmd_r.sep_kind;
            res_r.word_char      <= '0;
            res_r.char_index     <= '0;
            res_r.word_length    <= '0;
            res_r.word_truncated <= 1'b0;
            res_r.last           <= 1'b1;
            state_r              <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Character index stays inside the stored word
  a_idx_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHARS |-> LW'(idx_r) < len_l)
    else $error("identifier index past word length");

  // A popped command always starts token emission
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r != ST_IDLE)
    else $error("command popped without emission");

endmodule

/* sv/idl_token_scanner_unit.sv */
// idl_token_scanner_unit: IDL lexical scanner, one text byte per request in,
// one token per request out. Depends on its_pkg, its_if, its_front, its_cmd_fifo, its_back.
// Path: the byte that ends a token is classified, queued as a command, then emitted.
// Flow: inside a word a new byte is taken while the queue is not full; the emitter
// sends one token per stored character of an identifier, one for a keyword and one per
// separator; input stalls when the two-entry queue is full or,
// between words, both word buffer banks are still being emitted.
// Reset: synchronous active-low rst_n clears all control state; no clearing pass.
`timescale 1ns / 1ps

module idl_token_scanner_unit #(
  parameter int MAX_WORD = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  its_in_if.sink    in_ch,
  its_out_if.source out_ch
);
  import its_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WORD) + 1;

  logic              push, pop, full, empty, word_done;
  cmd_t              push_cmd, head;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  result_t           res;

  // Classifier and word buffer
  its_front #(.MAX_WORD(MAX_WORD), .ADDR_W(ADDR_W)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .text_char   (in_ch.text_char),
    .end_of_text (in_ch.end_of_text),
    .push        (push),
    .cmd         (push_cmd),
    .fifo_full   (full),
    .word_done   (word_done),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // Command queue
  its_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // Token emitter
  its_back #(.MAX_WORD(MAX_WORD), .ADDR_W(ADDR_W)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (empty),
    .head       (head),
    .pop        (pop),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .word_done  (word_done),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (res)
  );

  assign out_ch.token_kind     = res.token_kind;
  assign out_ch.word_char      = res.word_char;
  assign out_ch.char_index     = res.char_index;
  assign out_ch.word_length    = res.word_length;
  assign out_ch.word_truncated = res.word_truncated;
  assign out_ch.last           = res.last;

endmodule
